// ===== design/volume_boundary_weight_blend_macros.svh =====
`ifndef VOLUME_BOUNDARY_WEIGHT_BLEND_MACROS_SVH
`define VOLUME_BOUNDARY_WEIGHT_BLEND_MACROS_SVH

// same-cycle implication, off during reset
`define VBWB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define VBWB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vbwb_pkg.sv =====
`timescale 1ns / 1ps

package vbwb_pkg;

    localparam int DEF_MAX_X = 256;
    localparam int DEF_MAX_Y = 256;
    localparam int MAX_Z = 1024;

    localparam int GRAD_W = 16;
    localparam int X_SIZE_W = 9;
    localparam int Y_SIZE_W = 9;
    localparam int Z_SIZE_W = 11;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [X_SIZE_W-1:0] X_SIZE_RST = 9'd256;
    localparam logic [Y_SIZE_W-1:0] Y_SIZE_RST = 9'd256;
    localparam logic [Z_SIZE_W-1:0] Z_SIZE_RST = 11'd1;

    localparam logic [GRAD_W-1:0] FULL_SCALE = 16'd65000;
    localparam logic [GRAD_W-1:0] EDGE_SCALE = 16'd39000;
    localparam logic [GRAD_W-1:0] EDGE_BONUS = 16'd26000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_SIZE,
        REG_Y_SIZE,
        REG_Z_SIZE,
        REG_GRAD_MAX,
        REG_BOUNDARY_MODE
    } reg_idx_t;

endpackage

// ===== design/vbwb_ram.sv =====
`timescale 1ns / 1ps

module vbwb_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/volume_boundary_weight_blend.sv =====
// Arc weight generator for a 3D volume streamed in raster order (x fastest, then y, then z).
// Voxel channel: voxel_valid / voxel_stall with grad_value, mask_bit and drain. A drain
// transfer carries no voxel and only pushes out results still pending after the volume's last voxel.
// Result channel: result_valid / result_stall with weight and last_voxel; last_voxel marks
// the final voxel of the volume, after which the next voxel starts a new volume.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; write it only while
// the block is idle. A geometry write restarts the volume.
// The weight of a voxel comes out once its whole 6-neighbourhood has arrived: one plane plus
// one row plus one voxel later in the stream, or at the end on drains and other later transfers.
// A voxel transfer that yields a result holds voxel_stall high through reads of the voxel
// and its six neighbours on the single read port of the mask/gradient ring RAM, a product on
// the shared multiplier and a 2-bit-per-cycle restoring divider (skipped if grad_max is zero
// or below the gradient); ST_FIN loads the result. A transfer without result returns to ST_IDLE.
// If the result register is still stalled when a weight is ready, the block waits there;
// a result held in the register does not block the next voxel transfer.
// After reset and after each geometry write, setup states compute plane size and volume
// size on the shared multiplier, and the lag; voxel_stall is high meanwhile. Reset clears the
// positions and restores register defaults; the ring RAM needs no clearing.
`timescale 1ns / 1ps
`include "volume_boundary_weight_blend_macros.svh"

module volume_boundary_weight_blend #(
    parameter int MAX_X = vbwb_pkg::DEF_MAX_X,
    parameter int MAX_Y = vbwb_pkg::DEF_MAX_Y
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            voxel_valid,
    output logic                            voxel_stall,
    input  logic [vbwb_pkg::GRAD_W-1:0]     grad_value,
    input  logic                            mask_bit,
    input  logic                            drain,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [vbwb_pkg::GRAD_W-1:0]     weight,
    output logic                            last_voxel,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vbwb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vbwb_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int GW = vbwb_pkg::GRAD_W;
    localparam longint PLANE_MAX = longint'(MAX_X) * longint'(MAX_Y);
    localparam int XW = $clog2(MAX_X + 1);
    localparam int YW = $clog2(MAX_Y + 1);
    localparam int ZW = $clog2(vbwb_pkg::MAX_Z + 1);
    localparam int PW = $clog2(PLANE_MAX + 1);
    localparam int TW = $clog2(PLANE_MAX * longint'(vbwb_pkg::MAX_Z) + 1);
    localparam int AW = $clog2(2 * PLANE_MAX + longint'(MAX_X) + 1);
    localparam int RING_DEPTH = 1 << AW;
    localparam int MW = (PW > GW) ? PW : GW;
    localparam int MB = GW;
    localparam int RW = GW + 1;
    localparam int NW = 2 * GW + 2;
    localparam int DIV_STEPS = GW / 2;
    localparam int DCW = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        ST_SET_PLANE,
        ST_SET_TOTAL,
        ST_IDLE,
        ST_DECIDE,
        ST_NBR,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        NB_CENTER,
        NB_XM,
        NB_XP,
        NB_YM,
        NB_YP,
        NB_ZM,
        NB_ZP,
        NB_DONE
    } nbr_t;

    state_t state_reg, state_next;
    nbr_t   nbr_reg, nbr_next;
    nbr_t   rd_kind_reg, rd_kind_next;
    logic   rd_pend_reg, rd_pend_next;

    logic [vbwb_pkg::X_SIZE_W-1:0] x_size_reg, x_size_next;
    logic [vbwb_pkg::Y_SIZE_W-1:0] y_size_reg, y_size_next;
    logic [vbwb_pkg::Z_SIZE_W-1:0] z_size_reg, z_size_next;
    logic [GW-1:0]                 grad_max_reg, grad_max_next;
    logic                          bmode_reg, bmode_next;

    logic [PW-1:0] plane_reg, plane_next;
    logic [TW-1:0] total_reg, total_next;
    logic [TW-1:0] lag_reg, lag_next;
    logic [TW-1:0] in_pos_reg, in_pos_next;
    logic [TW-1:0] out_pos_reg, out_pos_next;
    logic [XW-1:0] xo_reg, xo_next;
    logic [YW-1:0] yo_reg, yo_next;
    logic [ZW-1:0] zo_reg, zo_next;

    logic [GW-1:0]   grad_in_reg, grad_in_next;
    logic            mask_in_reg, mask_in_next;
    logic            drain_in_reg, drain_in_next;
    logic            m_reg, m_next;
    logic [GW-1:0]   g_reg, g_next;
    logic            edge_reg, edge_next;
    logic [2*GW-1:0] prod_reg, prod_next;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [GW-1:0]   num_lo_reg, num_lo_next;
    logic [GW-1:0]   q_reg, q_next;
    logic [DCW-1:0]  div_cnt_reg, div_cnt_next;

    logic          result_valid_reg, result_valid_next;
    logic [GW-1:0] weight_reg, weight_next;
    logic          last_reg, last_next;

    logic [XW-1:0] xs_c;
    logic [YW-1:0] ys_c;
    logic [ZW-1:0] zs_c;
    logic [GW-1:0] scale;
    logic [7:0]    nb_ok;

    logic [MW-1:0]    mul_a;
    logic [MB-1:0]    mul_b;
    logic [MW+MB-1:0] mul_p;

    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_rd_addr;
    logic [GW:0]   ram_rd_data;

    logic voxel_take;
    logic cfg_take;
    logic out_free;
    logic fin_last;
    logic vox;
    logic emit;

    logic [RW-1:0] den;
    logic [NW-1:0] num;
    logic [RW:0]   t1;
    logic [RW:0]   t2;
    logic          ge1;
    logic          ge2;
    logic [RW-1:0] r1;
    logic [RW-1:0] r2;

    // clamped geometry
    always_comb
    begin
        if (x_size_reg == '0)
            xs_c = XW'(1);
        else if (32'(x_size_reg) > MAX_X)
            xs_c = XW'(MAX_X);
        else
            xs_c = XW'(x_size_reg);

        if (y_size_reg == '0)
            ys_c = YW'(1);
        else if (32'(y_size_reg) > MAX_Y)
            ys_c = YW'(MAX_Y);
        else
            ys_c = YW'(y_size_reg);

        if (z_size_reg == '0)
            zs_c = ZW'(1);
        else if (32'(z_size_reg) > vbwb_pkg::MAX_Z)
            zs_c = ZW'(vbwb_pkg::MAX_Z);
        else
            zs_c = ZW'(z_size_reg);
    end

    assign scale = bmode_reg ? vbwb_pkg::EDGE_SCALE : vbwb_pkg::FULL_SCALE;

    // which neighbours lie inside the volume
    always_comb
    begin
        nb_ok            = '0;
        nb_ok[NB_CENTER] = 1'b1;
        nb_ok[NB_XM]     = bmode_reg && (xo_reg != '0);
        nb_ok[NB_XP]     = bmode_reg && (xo_reg != xs_c - XW'(1));
        nb_ok[NB_YM]     = bmode_reg && (yo_reg != '0);
        nb_ok[NB_YP]     = bmode_reg && (yo_reg != ys_c - YW'(1));
        nb_ok[NB_ZM]     = bmode_reg && (zo_reg != '0);
        nb_ok[NB_ZP]     = bmode_reg && (zo_reg != zs_c - ZW'(1));
    end

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SET_PLANE:
            begin
                mul_a = MW'(xs_c);
                mul_b = MB'(ys_c);
            end
            ST_SET_TOTAL:
            begin
                mul_a = MW'(plane_reg);
                mul_b = MB'(zs_c);
            end
            ST_MUL:
            begin
                mul_a = MW'(g_reg);
                mul_b = scale;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = (MW+MB)'(mul_a) * (MW+MB)'(mul_b);

    // ring address of the current read
    always_comb
    begin
        unique case (nbr_reg)
            NB_XM:   ram_rd_addr = out_pos_reg[AW-1:0] - AW'(1);
            NB_XP:   ram_rd_addr = out_pos_reg[AW-1:0] + AW'(1);
            NB_YM:   ram_rd_addr = out_pos_reg[AW-1:0] - AW'(xs_c);
            NB_YP:   ram_rd_addr = out_pos_reg[AW-1:0] + AW'(xs_c);
            NB_ZM:   ram_rd_addr = out_pos_reg[AW-1:0] - AW'(plane_reg);
            NB_ZP:   ram_rd_addr = out_pos_reg[AW-1:0] + AW'(plane_reg);
            default: ram_rd_addr = out_pos_reg[AW-1:0];
        endcase
    end

    assign ram_we = (state_reg == ST_DECIDE) && vox;
    assign ram_re = (state_reg == ST_NBR) && (nbr_reg != NB_DONE);

    vbwb_ram #(
        .WIDTH (GW + 1),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (in_pos_reg[AW-1:0]),
        .wr_data ({mask_in_reg, grad_in_reg}),
        .rd_en   (ram_re),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // two quotient bits per step
    always_comb
    begin
        den = {grad_max_reg, 1'b0};
        num = NW'({prod_reg, 1'b0}) + NW'(grad_max_reg);
        t1  = {rem_reg, num_lo_reg[GW-1]};
        ge1 = t1 >= {1'b0, den};
        r1  = ge1 ? RW'(t1 - {1'b0, den}) : t1[RW-1:0];
        t2  = {r1, num_lo_reg[GW-2]};
        ge2 = t2 >= {1'b0, den};
        r2  = ge2 ? RW'(t2 - {1'b0, den}) : t2[RW-1:0];
    end

    assign cfg_ready   = (state_reg == ST_IDLE) || (state_reg == ST_SET_PLANE)
                         || (state_reg == ST_SET_TOTAL);
    assign voxel_stall = (state_reg != ST_IDLE) || cfg_valid;
    assign voxel_take  = voxel_valid && !voxel_stall;
    assign cfg_take    = cfg_valid && cfg_ready;
    assign out_free    = !result_valid_reg || !result_stall;
    assign fin_last    = (out_pos_reg + TW'(1)) == total_reg;
    assign vox         = !drain_in_reg && (in_pos_reg < total_reg);
    assign emit        = vox ? ((in_pos_reg - out_pos_reg) >= lag_reg)
                             : ((in_pos_reg >= total_reg) && (out_pos_reg < in_pos_reg));

    always_comb
    begin
        state_next        = state_reg;
        nbr_next          = nbr_reg;
        rd_kind_next      = rd_kind_reg;
        rd_pend_next      = rd_pend_reg;
        x_size_next       = x_size_reg;
        y_size_next       = y_size_reg;
        z_size_next       = z_size_reg;
        grad_max_next     = grad_max_reg;
        bmode_next        = bmode_reg;
        plane_next        = plane_reg;
        total_next        = total_reg;
        lag_next          = lag_reg;
        in_pos_next       = in_pos_reg;
        out_pos_next      = out_pos_reg;
        xo_next           = xo_reg;
        yo_next           = yo_reg;
        zo_next           = zo_reg;
        grad_in_next      = grad_in_reg;
        mask_in_next      = mask_in_reg;
        drain_in_next     = drain_in_reg;
        m_next            = m_reg;
        g_next            = g_reg;
        edge_next         = edge_reg;
        prod_next         = prod_reg;
        rem_next          = rem_reg;
        num_lo_next       = num_lo_reg;
        q_next            = q_reg;
        div_cnt_next      = div_cnt_reg;
        result_valid_next = result_valid_reg;
        weight_next       = weight_reg;
        last_next         = last_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_SET_PLANE:
            begin
                plane_next = mul_p[PW-1:0];
                state_next = ST_SET_TOTAL;
            end
            ST_SET_TOTAL:
            begin
                total_next = TW'(mul_p);
                lag_next   = TW'(plane_reg) + TW'(xs_c) + TW'(1);
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (voxel_take)
                begin
                    grad_in_next  = grad_value;
                    mask_in_next  = mask_bit;
                    drain_in_next = drain;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (vox)
                begin
                    in_pos_next = in_pos_reg + TW'(1);
                end
                if (emit)
                begin
                    nbr_next     = NB_CENTER;
                    rd_pend_next = 1'b0;
                    edge_next    = 1'b0;
                    state_next   = ST_NBR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_NBR:
            begin
                if (nbr_reg != NB_DONE)
                begin
                    nbr_next     = nbr_t'(nbr_reg + 3'd1);
                    rd_kind_next = nbr_reg;
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    state_next   = ST_MUL;
                end
                if (rd_pend_reg)
                begin
                    if (rd_kind_reg == NB_CENTER)
                    begin
                        m_next = ram_rd_data[GW];
                        g_next = ram_rd_data[GW-1:0];
                    end
                    else if (nb_ok[rd_kind_reg] && (ram_rd_data[GW] != m_reg))
                    begin
                        edge_next = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = mul_p[2*GW-1:0];
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                if (grad_max_reg == '0)
                begin
                    q_next     = '0;
                    state_next = ST_FIN;
                end
                else if (g_reg > grad_max_reg)
                begin
                    q_next     = scale;
                    state_next = ST_FIN;
                end
                else
                begin
                    rem_next     = num[NW-2:GW];
                    num_lo_next  = num[GW-1:0];
                    q_next       = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next     = r2;
                num_lo_next  = num_lo_reg << 2;
                q_next       = {q_reg[GW-3:0], ge1, ge2};
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    weight_next       = q_reg + (edge_reg ? vbwb_pkg::EDGE_BONUS : '0);
                    last_next         = fin_last;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                    if (fin_last)
                    begin
                        in_pos_next  = '0;
                        out_pos_next = '0;
                        xo_next      = '0;
                        yo_next      = '0;
                        zo_next      = '0;
                    end
                    else
                    begin
                        out_pos_next = out_pos_reg + TW'(1);
                        if (xo_reg == xs_c - XW'(1))
                        begin
                            xo_next = '0;
                            if (yo_reg == ys_c - YW'(1))
                            begin
                                yo_next = '0;
                                zo_next = zo_reg + ZW'(1);
                            end
                            else
                            begin
                                yo_next = yo_reg + YW'(1);
                            end
                        end
                        else
                        begin
                            xo_next = xo_reg + XW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_take)
        begin
            unique case (cfg_index)
                vbwb_pkg::REG_X_SIZE:
                begin
                    x_size_next = cfg_data[vbwb_pkg::X_SIZE_W-1:0];
                    state_next  = ST_SET_PLANE;
                end
                vbwb_pkg::REG_Y_SIZE:
                begin
                    y_size_next = cfg_data[vbwb_pkg::Y_SIZE_W-1:0];
                    state_next  = ST_SET_PLANE;
                end
                vbwb_pkg::REG_Z_SIZE:
                begin
                    z_size_next = cfg_data[vbwb_pkg::Z_SIZE_W-1:0];
                    state_next  = ST_SET_PLANE;
                end
                vbwb_pkg::REG_GRAD_MAX:
                begin
                    grad_max_next = cfg_data[GW-1:0];
                end
                vbwb_pkg::REG_BOUNDARY_MODE:
                begin
                    bmode_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
            // geometry change restarts the volume
            if (state_next == ST_SET_PLANE)
            begin
                in_pos_next  = '0;
                out_pos_next = '0;
                xo_next      = '0;
                yo_next      = '0;
                zo_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_SET_PLANE;
            nbr_reg          <= NB_CENTER;
            rd_kind_reg      <= NB_CENTER;
            rd_pend_reg      <= 1'b0;
            x_size_reg       <= vbwb_pkg::X_SIZE_RST;
            y_size_reg       <= vbwb_pkg::Y_SIZE_RST;
            z_size_reg       <= vbwb_pkg::Z_SIZE_RST;
            grad_max_reg     <= '0;
            bmode_reg        <= 1'b0;
            plane_reg        <= '0;
            total_reg        <= '0;
            lag_reg          <= '0;
            in_pos_reg       <= '0;
            out_pos_reg      <= '0;
            xo_reg           <= '0;
            yo_reg           <= '0;
            zo_reg           <= '0;
            grad_in_reg      <= '0;
            mask_in_reg      <= 1'b0;
            drain_in_reg     <= 1'b0;
            m_reg            <= 1'b0;
            g_reg            <= '0;
            edge_reg         <= 1'b0;
            prod_reg         <= '0;
            rem_reg          <= '0;
            num_lo_reg       <= '0;
            q_reg            <= '0;
            div_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
            weight_reg       <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            nbr_reg          <= nbr_next;
            rd_kind_reg      <= rd_kind_next;
            rd_pend_reg      <= rd_pend_next;
            x_size_reg       <= x_size_next;
            y_size_reg       <= y_size_next;
            z_size_reg       <= z_size_next;
            grad_max_reg     <= grad_max_next;
            bmode_reg        <= bmode_next;
            plane_reg        <= plane_next;
            total_reg        <= total_next;
            lag_reg          <= lag_next;
            in_pos_reg       <= in_pos_next;
            out_pos_reg      <= out_pos_next;
            xo_reg           <= xo_next;
            yo_reg           <= yo_next;
            zo_reg           <= zo_next;
            grad_in_reg      <= grad_in_next;
            mask_in_reg      <= mask_in_next;
            drain_in_reg     <= drain_in_next;
            m_reg            <= m_next;
            g_reg            <= g_next;
            edge_reg         <= edge_next;
            prod_reg         <= prod_next;
            rem_reg          <= rem_next;
            num_lo_reg       <= num_lo_next;
            q_reg            <= q_next;
            div_cnt_reg      <= div_cnt_next;
            result_valid_reg <= result_valid_next;
            weight_reg       <= weight_next;
            last_reg         <= last_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign weight       = weight_reg;
    assign last_voxel   = last_reg;

    `VBWB_ASSERT_IMPL(a_weight_range, clk, rst_n, result_valid,
        weight <= vbwb_pkg::FULL_SCALE, "weight above full scale")
    `VBWB_ASSERT_IMPL(a_pos_order, clk, rst_n, 1'b1,
        out_pos_reg <= in_pos_reg, "more results than voxels")
    `VBWB_ASSERT_IMPL(a_in_bound, clk, rst_n, state_reg == ST_IDLE,
        in_pos_reg <= total_reg, "input position beyond volume")
    `VBWB_ASSERT_NEXT(a_volume_wrap, clk, rst_n, (state_reg == ST_FIN) && out_free && fin_last,
        (in_pos_reg == '0) && (out_pos_reg == '0), "positions not cleared after last voxel")

endmodule

// ===== verif/volume_boundary_weight_blend_tb.sv =====
`timescale 1ns / 1ps

module volume_boundary_weight_blend_tb;
    import vbwb_pkg::*;

    localparam int unsigned ITEMS = 1750;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLDOFF_CYCLES = 400;
    localparam int unsigned IDLE_PCT = 16;
    localparam int unsigned MASK_RING = 2 * DEF_MAX_X * DEF_MAX_Y + DEF_MAX_X + 1;
    localparam int unsigned GRAD_RING = DEF_MAX_X * DEF_MAX_Y + DEF_MAX_X + 1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [GRAD_W-1:0] grad;
        logic              mask;
        logic              drn;
    } voxel_item_t;

    typedef struct packed {
        logic [GRAD_W-1:0] weight;
        logic              last_voxel;
    } arc_weight_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  voxel_valid = 1'b0;
    logic                  voxel_stall;
    logic [GRAD_W-1:0]     grad_value = '0;
    logic                  mask_bit = 1'b0;
    logic                  drain = 1'b0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [GRAD_W-1:0]     weight;
    logic                  last_voxel;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // block registers and stream position as the block should hold them
    logic [X_SIZE_W-1:0] x_reg = X_SIZE_RST;
    logic [Y_SIZE_W-1:0] y_reg = Y_SIZE_RST;
    logic [Z_SIZE_W-1:0] z_reg = Z_SIZE_RST;
    logic [GRAD_W-1:0]   gmax_reg = '0;
    logic                bmode_reg = 1'b0;
    bit                  mask_hist [MASK_RING];
    logic [GRAD_W-1:0]   grad_hist [GRAD_RING];
    int unsigned         in_pos = 0;
    int unsigned         out_pos = 0;

    voxel_item_t stream_q [$];
    arc_weight_t weights_due [$];

    bit          steady = 1'b0;
    int unsigned holdoff_requests = 0;
    int unsigned holdoff_done = 0;
    int unsigned holdoff_left = 0;
    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned weights_checked = 0;
    int unsigned volumes_done = 0;
    int unsigned transfers = 0;
    int unsigned voxels_queued = 0;
    int unsigned reg_writes = 0;
    int unsigned fed_in_volume = 0;
    int unsigned mask_mode = 0;
    int unsigned mask_cut = 0;

    volume_boundary_weight_blend dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .voxel_valid  (voxel_valid),
        .voxel_stall  (voxel_stall),
        .grad_value   (grad_value),
        .mask_bit     (mask_bit),
        .drain        (drain),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .weight       (weight),
        .last_voxel   (last_voxel),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned x_dim();
        return clamp_dim(x_reg, DEF_MAX_X);
    endfunction

    function automatic int unsigned y_dim();
        return clamp_dim(y_reg, DEF_MAX_Y);
    endfunction

    function automatic int unsigned z_dim();
        return clamp_dim(z_reg, MAX_Z);
    endfunction

    function automatic bit mask_of(int unsigned p);
        return mask_hist[p % MASK_RING];
    endfunction

    function automatic logic [GRAD_W-1:0] blended_weight(int unsigned p, int unsigned xs,
                                                         int unsigned ys, int unsigned zs);
        int unsigned plane;
        int unsigned x;
        int unsigned y;
        int unsigned z;
        bit m;
        bit border;
        longint unsigned g;
        longint unsigned scale;
        longint unsigned part;
        plane = xs * ys;
        x = p % xs;
        y = (p / xs) % ys;
        z = p / plane;
        m = mask_of(p);
        border = 1'b0;
        scale = bmode_reg ? EDGE_SCALE : FULL_SCALE;
        g = grad_hist[p % GRAD_RING];
        if (bmode_reg)
        begin
            if (x > 0 && mask_of(p - 1) != m)
                border = 1'b1;
            if (x + 1 < xs && mask_of(p + 1) != m)
                border = 1'b1;
            if (y > 0 && mask_of(p - xs) != m)
                border = 1'b1;
            if (y + 1 < ys && mask_of(p + xs) != m)
                border = 1'b1;
            if (z > 0 && mask_of(p - plane) != m)
                border = 1'b1;
            if (z + 1 < zs && mask_of(p + plane) != m)
                border = 1'b1;
        end
        if (gmax_reg == 0)
            part = 0;
        else if (g > gmax_reg)
            part = scale;
        else
            part = (2 * scale * g + gmax_reg) / (2 * longint'(gmax_reg));
        if (border)
            part = part + EDGE_BONUS;
        return part[GRAD_W-1:0];
    endfunction

    task automatic take_voxel_transfer(logic [GRAD_W-1:0] g, logic m, logic drn);
        int unsigned xs;
        int unsigned ys;
        int unsigned zs;
        int unsigned total;
        int unsigned lag;
        int unsigned p;
        bit emit;
        arc_weight_t due;
        xs = x_dim();
        ys = y_dim();
        zs = z_dim();
        total = xs * ys * zs;
        lag = xs * ys + xs + 1;
        p = out_pos;
        emit = 1'b0;
        if (!drn && in_pos < total)
        begin
            // the pending voxel is read before the new one lands in the rings
            if (in_pos - out_pos >= lag)
            begin
                emit = 1'b1;
                due.weight = blended_weight(p, xs, ys, zs);
                due.last_voxel = (p + 1 == total);
                weights_due.push_back(due);
            end
            mask_hist[in_pos % MASK_RING] = m;
            grad_hist[in_pos % GRAD_RING] = g;
            in_pos++;
        end
        else if (in_pos >= total && out_pos < in_pos)
        begin
            emit = 1'b1;
            due.weight = blended_weight(p, xs, ys, zs);
            due.last_voxel = (p + 1 == total);
            weights_due.push_back(due);
        end
        if (emit)
        begin
            out_pos++;
            if (p + 1 >= total)
            begin
                in_pos = 0;
                out_pos = 0;
            end
        end
    endtask

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        if (mismatches <= 20)
            $display("mismatch on result %0d: %s got %0d want %0d", weights_checked, what,
                     got, want);
    endtask

    // sender
    always @(posedge clk)
    begin
        voxel_item_t nxt;
        bit offer;
        if (!rst_n)
        begin
            voxel_valid <= 1'b0;
        end
        else
        begin
            if (voxel_valid && !voxel_stall)
            begin
                take_voxel_transfer(grad_value, mask_bit, drain);
                transfers++;
            end
            if (!voxel_valid || !voxel_stall)
            begin
                offer = stream_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT);
                if (offer)
                begin
                    nxt = stream_q.pop_front();
                    grad_value <= nxt.grad;
                    mask_bit <= nxt.mask;
                    drain <= nxt.drn;
                end
                voxel_valid <= offer;
            end
        end
    end

    // receiver stall, with long hold-offs on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (holdoff_left > 0)
        begin
            result_stall <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end
        else if (holdoff_done < holdoff_requests)
        begin
            result_stall <= 1'b1;
            holdoff_done <= holdoff_done + 1;
            holdoff_left <= HOLDOFF_CYCLES;
        end
        else
        begin
            result_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        arc_weight_t due;
        if (rst_n && result_valid && !result_stall)
        begin
            if (weights_due.size() == 0)
            begin
                report_mismatch("unexpected transfer, weight", weight, 0);
            end
            else
            begin
                due = weights_due.pop_front();
                if (weight !== due.weight)
                    report_mismatch("weight", weight, due.weight);
                if (last_voxel !== due.last_voxel)
                    report_mismatch("last_voxel", last_voxel, due.last_voxel);
            end
            if (last_voxel === 1'b1)
                volumes_done++;
            weights_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     weights_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            REG_X_SIZE:
            begin
                x_reg = data[X_SIZE_W-1:0];
                in_pos = 0;
                out_pos = 0;
            end
            REG_Y_SIZE:
            begin
                y_reg = data[Y_SIZE_W-1:0];
                in_pos = 0;
                out_pos = 0;
            end
            REG_Z_SIZE:
            begin
                z_reg = data[Z_SIZE_W-1:0];
                in_pos = 0;
                out_pos = 0;
            end
            REG_GRAD_MAX: gmax_reg = data[GRAD_W-1:0];
            REG_BOUNDARY_MODE: bmode_reg = data[0];
            default: ;
        endcase
    endtask

    // wait until every queued transfer is taken and every weight has come back
    task automatic settle();
        do
            @(posedge clk);
        while (stream_q.size() != 0 || voxel_valid || weights_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_voxel(logic [GRAD_W-1:0] g, logic m);
        voxel_item_t item;
        item.grad = g;
        item.mask = m;
        item.drn = 1'b0;
        stream_q.push_back(item);
        voxels_queued++;
    endtask

    task automatic queue_drain();
        voxel_item_t item;
        item.grad = GRAD_W'($urandom);
        item.mask = 1'($urandom);
        item.drn = 1'b1;
        stream_q.push_back(item);
    endtask

    function automatic logic [GRAD_W-1:0] pick_grad();
        int unsigned g;
        case ($urandom_range(0, 9))
            0: g = 0;
            1: g = 16'hFFFF;
            2: g = gmax_reg;
            3: g = gmax_reg + 1;
            4: g = gmax_reg - 1;
            5, 6: g = $urandom_range(0, gmax_reg);
            default: g = $urandom_range(0, 16'hFFFF);
        endcase
        return g[GRAD_W-1:0];
    endfunction

    function automatic logic [GRAD_W-1:0] pick_grad_max();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 16'hFFFF;
            2: return $urandom_range(1, 15);
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    function automatic logic pick_mask(int unsigned idx);
        int unsigned xs;
        int unsigned ys;
        xs = x_dim();
        ys = y_dim();
        case (mask_mode)
            0: return 1'b0;
            1: return 1'b1;
            2, 3: return 1'($urandom);
            default: return (idx % xs + (idx / xs) % ys + idx / (xs * ys)) >= mask_cut;
        endcase
    endfunction

    // feed voxels of the current volume up to index upto, then flush a finished volume
    task automatic feed_volume(int unsigned upto);
        int unsigned total;
        int unsigned lag;
        int unsigned tail;
        total = x_dim() * y_dim() * z_dim();
        lag = x_dim() * y_dim() + x_dim() + 1;
        if (fed_in_volume == 0)
        begin
            mask_mode = $urandom_range(0, 5);
            mask_cut = $urandom_range(0, x_dim() + y_dim() + z_dim());
        end
        while (fed_in_volume < upto)
        begin
            if ($urandom_range(0, 99) < 5)
                queue_drain();
            queue_voxel(pick_grad(), pick_mask(fed_in_volume));
            fed_in_volume++;
        end
        if (fed_in_volume == total)
        begin
            tail = (total > lag) ? lag : total;
            repeat (tail)
            begin
                if ($urandom_range(0, 99) < 20)
                    stream_q.push_back({pick_grad(), 1'($urandom), 1'b0});
                else
                    queue_drain();
            end
            if ($urandom_range(0, 99) < 30)
                queue_drain();
            fed_in_volume = 0;
        end
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned total;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // 2x2x2 in boundary mode: saturation, both gradient extremes, ignored drains
        write_reg(REG_X_SIZE, 2);
        write_reg(REG_Y_SIZE, 2);
        write_reg(REG_Z_SIZE, 2);
        write_reg(REG_GRAD_MAX, 1000);
        write_reg(REG_BOUNDARY_MODE, 1);
        queue_drain();
        queue_voxel(16'd0, 1'b0);
        queue_voxel(16'hFFFF, 1'b1);
        queue_voxel(16'd1000, 1'b0);
        queue_voxel(16'd500, 1'b1);
        queue_drain();
        queue_voxel(16'd999, 1'b0);
        queue_voxel(16'd1, 1'b1);
        queue_voxel(16'd1001, 1'b1);
        queue_voxel(16'hFFFF, 1'b0);
        // a voxel past the end of the volume only flushes
        queue_voxel(16'hFFFF, 1'b1);
        repeat (6) queue_drain();
        queue_drain();
        settle();

        // single voxel volume from zero sizes, zero maximum, unknown register
        write_reg(REG_X_SIZE, 0);
        write_reg(REG_Y_SIZE, 1);
        write_reg(REG_Z_SIZE, 0);
        write_reg(REG_GRAD_MAX, 0);
        write_reg(REG_BOUNDARY_MODE, 0);
        write_reg(REG_SPARE, 16'hFFFF);
        queue_voxel(16'd40000, 1'b1);
        queue_drain();
        queue_voxel(16'd0, 1'b0);
        queue_voxel(16'd123, 1'b1);
        settle();

        // widest row, clamped from an oversized value
        write_reg(REG_X_SIZE, 300);
        write_reg(REG_Y_SIZE, 1);
        write_reg(REG_Z_SIZE, 1);
        write_reg(REG_GRAD_MAX, 16'hFFFF);
        write_reg(REG_BOUNDARY_MODE, 1);
        holdoff_requests++;
        feed_volume(256);
        settle();

        write_reg(REG_X_SIZE, 1);
        write_reg(REG_Y_SIZE, 256);
        write_reg(REG_GRAD_MAX, pick_grad_max());
        feed_volume(256);
        settle();

        // deepest volume, partly fed; the loop below may cut it short with a size change
        write_reg(REG_Y_SIZE, 1);
        write_reg(REG_Z_SIZE, 1024);
        write_reg(REG_BOUNDARY_MODE, 0);
        feed_volume(60);

        phase = 0;
        while (voxels_queued < ITEMS)
        begin
            settle();
            steady = (phase == 2);
            if (fed_in_volume == 0 || $urandom_range(0, 99) < 60)
            begin
                write_reg(REG_X_SIZE, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
                write_reg(REG_Y_SIZE, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
                write_reg(REG_Z_SIZE, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5));
                fed_in_volume = 0;
            end
            if ($urandom_range(0, 99) < 60)
                write_reg(REG_GRAD_MAX, pick_grad_max());
            if ($urandom_range(0, 99) < 60)
                write_reg(REG_BOUNDARY_MODE, 1'($urandom));
            if (phase == 1 || $urandom_range(0, 99) < 10)
                holdoff_requests++;
            total = x_dim() * y_dim() * z_dim();
            repeat ($urandom_range(1, 3))
            begin
                feed_volume(total);
                if (phase == 0 || $urandom_range(0, 99) < 15)
                    settle();
            end
            if (total > 1 && $urandom_range(0, 99) < 30)
                feed_volume($urandom_range(1, total - 1));
            phase++;
        end
        steady = 1'b0;
        settle();

        $display("%0d voxels in %0d transfers over %0d register writes; %0d weights checked",
                 voxels_queued, transfers, reg_writes, weights_checked);
        $display("%0d volumes completed, %0d receiver hold-offs, %0d mismatches",
                 volumes_done, holdoff_done, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
